// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and held off by rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define PRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define PRS_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`endif

// ===== rtl/prs_pkg.sv =====
// ---------------------------------------------------------------------------
// prs_pkg
// Types, widths and constants shared by the precharge run sequencer.
// ---------------------------------------------------------------------------
package prs_pkg;

  localparam int ADC_BITS     = 10;
  localparam int TIME_BITS    = 32;
  localparam int PERIOD_BITS  = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int PHASE_BITS   = 3;
  localparam int FLAG_BITS    = 4;

  typedef logic [ADC_BITS-1:0]    adc_code_t;
  typedef logic [TIME_BITS-1:0]   stamp_t;
  typedef logic [PERIOD_BITS-1:0] period_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TEMP_LIMIT    = CFG_IDX_BITS'(0),
    REG_CURRENT_LIMIT = CFG_IDX_BITS'(1),
    REG_COIL_ON       = CFG_IDX_BITS'(2),
    REG_CAP_MIN       = CFG_IDX_BITS'(3),
    REG_CAP_READY     = CFG_IDX_BITS'(4),
    REG_FLASH_PERIOD  = CFG_IDX_BITS'(5)
  } cfg_reg_t;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_PRE   = 5'b00010,
    ST_WAIT  = 5'b00100,
    ST_RUN   = 5'b01000,
    ST_FAULT = 5'b10000
  } phase_state_t;

  // phase codes seen on the result port
  localparam logic [PHASE_BITS-1:0] PHASE_CODE_INIT  = PHASE_BITS'(0);
  localparam logic [PHASE_BITS-1:0] PHASE_CODE_PRE   = PHASE_BITS'(1);
  localparam logic [PHASE_BITS-1:0] PHASE_CODE_WAIT  = PHASE_BITS'(2);
  localparam logic [PHASE_BITS-1:0] PHASE_CODE_RUN   = PHASE_BITS'(3);
  localparam logic [PHASE_BITS-1:0] PHASE_CODE_FAULT = PHASE_BITS'(4);

  typedef struct packed {
    adc_code_t temp_limit;
    adc_code_t current_limit;
    adc_code_t coil_on;
    adc_code_t cap_min;
    adc_code_t cap_ready;
    period_t   flash_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    temp_limit:    ADC_BITS'(135),
    current_limit: ADC_BITS'(2),
    coil_on:       ADC_BITS'(784),
    cap_min:       ADC_BITS'(864),
    cap_ready:     ADC_BITS'(922),
    flash_period:  PERIOD_BITS'(500)
  };

  typedef struct packed {
    adc_code_t current;
    adc_code_t temp;
    adc_code_t cap;
    adc_code_t run_coil;
    adc_code_t pre_coil;
    stamp_t    now;
  } sample_t;

  // latched drive outputs
  typedef struct packed {
    logic shutdown;
    logic enable;
    logic ready;
    logic run;
    logic pre;
  } relay_t;

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
  } led_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    relay_t                relay;
    led_t                  led;
    logic [FLAG_BITS-1:0]  flags;
  } result_t;

  function automatic logic [PHASE_BITS-1:0] phase_code(input phase_state_t s);
    logic [PHASE_BITS-1:0] c;
    unique case (s)
      ST_INIT:  c = PHASE_CODE_INIT;
      ST_PRE:   c = PHASE_CODE_PRE;
      ST_WAIT:  c = PHASE_CODE_WAIT;
      ST_RUN:   c = PHASE_CODE_RUN;
      ST_FAULT: c = PHASE_CODE_FAULT;
      default:  c = PHASE_CODE_INIT;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/precharge_run_sequencer_core.sv =====
// ---------------------------------------------------------------------------
// precharge_run_sequencer_core
// Capacitor precharge and relay run sequencer, one control pass per beat.
// ---------------------------------------------------------------------------
// Each input beat is one sampled control pass; each pass yields exactly one
// result beat with the phase after the pass, the latched relay, enable,
// shutdown and LED drives, and the fault flags. The block takes one beat per
// clock cycle when the result side keeps up; a pass is captured in the input
// register and moves into the result register, which drives the result port;
// while the result side stalls, the pass waits in the input register.
// The sequencer state is updated in the same cycle that a pass moves into the
// result register, so the next pass already sees it. Configuration writes are
// always ready and take effect on the next pass.
`include "assert_macros.svh"

module precharge_run_sequencer_core
  import prs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input pass
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ADC_BITS-1:0]      current_code,
  input  logic [ADC_BITS-1:0]      temp_code,
  input  logic [ADC_BITS-1:0]      cap_code,
  input  logic [ADC_BITS-1:0]      run_coil_code,
  input  logic [ADC_BITS-1:0]      pre_coil_code,
  input  logic [TIME_BITS-1:0]     now_ms,
  // result
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PHASE_BITS-1:0]    phase,
  output logic                     precharge_close,
  output logic                     run_close,
  output logic                     table_ready,
  output logic                     switch_enable,
  output logic                     shutdown_request,
  output logic                     led_red,
  output logic                     led_green,
  output logic                     led_blue,
  output logic [FLAG_BITS-1:0]     fault_flags,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t    cfg;
  sample_t smp;
  logic    in_full;
  logic    advance;
  logic    in_take;
  result_t res;
  result_t res_reg;

  prs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: a pass moves on when the result register is free or draining
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp <= '{current: current_code, temp: temp_code, cap: cap_code,
               run_coil: run_coil_code, pre_coil: pre_coil_code, now: now_ms};
    end
  end

  prs_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .smp  (smp),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res;
    end
  end

  assign phase            = res_reg.phase;
  assign precharge_close  = res_reg.relay.pre;
  assign run_close        = res_reg.relay.run;
  assign table_ready      = res_reg.relay.ready;
  assign switch_enable    = res_reg.relay.enable;
  assign shutdown_request = res_reg.relay.shutdown;
  assign led_red          = res_reg.led.red;
  assign led_green        = res_reg.led.green;
  assign led_blue         = res_reg.led.blue;
  assign fault_flags      = res_reg.flags;

  // checks
  `PRS_ASSERT_IMPL(a_fault_no_enable, out_valid && phase == PHASE_CODE_FAULT,
    !switch_enable, "switch enabled in fault phase")
  `PRS_ASSERT_IMPL(a_run_closed, out_valid && phase == PHASE_CODE_RUN,
    run_close && table_ready, "run phase without run relay and ready")
  `PRS_ASSERT_IMPL(a_init_open, out_valid && phase == PHASE_CODE_INIT,
    !precharge_close && !run_close, "relay closed in init phase")
  `PRS_ASSERT(a_free_slot, !out_valid |-> !in_stall,
    "input stalled while result register empty")

endmodule

// ===== rtl/prs_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// prs_cfg_regs
// Threshold and flash period registers behind the configuration port.
// ---------------------------------------------------------------------------
module prs_cfg_regs
  import prs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  logic cfg_write;

  // writes always land at once
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  // register file, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TEMP_LIMIT:    cfg.temp_limit    <= cfg_data[ADC_BITS-1:0];
        REG_CURRENT_LIMIT: cfg.current_limit <= cfg_data[ADC_BITS-1:0];
        REG_COIL_ON:       cfg.coil_on       <= cfg_data[ADC_BITS-1:0];
        REG_CAP_MIN:       cfg.cap_min       <= cfg_data[ADC_BITS-1:0];
        REG_CAP_READY:     cfg.cap_ready     <= cfg_data[ADC_BITS-1:0];
        REG_FLASH_PERIOD:  cfg.flash_period  <= cfg_data[PERIOD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/prs_step.sv =====
// ---------------------------------------------------------------------------
// prs_step
// Fault checks, phase machine, entry and exit actions and LED control for
// one control pass; holds the sequencer state registers.
// ---------------------------------------------------------------------------
module prs_step
  import prs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  sample_t smp,
  input  cfg_t    cfg,
  output result_t res
);

  phase_state_t phase,       phase_next;
  stamp_t       flash_start, flash_start_next;
  logic         flash_lit,   flash_lit_next;
  relay_t       relay,       relay_next;
  led_t         led,         led_next;

  logic   run_on, pre_on, hw_run, hw_pre;
  logic   f_temp, f_cur, f_loop, f_cap, faulted;
  stamp_t elapsed;
  stamp_t start_mid;

  // coil decode and fault flags against the state held before the pass
  always_comb begin
    run_on  = smp.run_coil > cfg.coil_on;
    pre_on  = smp.pre_coil > cfg.coil_on;
    hw_run  = run_on;
    hw_pre  = !run_on && pre_on;
    f_temp  = smp.temp > cfg.temp_limit;
    f_cur   = smp.current > cfg.current_limit;
    f_loop  = !run_on && !pre_on;
    f_cap   = (smp.cap < cfg.cap_min) && (phase == ST_RUN || phase == ST_WAIT);
    faulted = f_temp || f_cur || f_loop || f_cap;
  end

  // phase transitions
  always_comb begin
    phase_next = phase;
    unique case (phase)
      ST_PRE: begin
        if (faulted || !hw_pre) phase_next = ST_FAULT;
        else if (smp.cap > cfg.cap_ready) phase_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (faulted) phase_next = ST_FAULT;
        else if (hw_run) phase_next = ST_RUN;
      end
      ST_RUN: begin
        if (faulted || !hw_run) phase_next = ST_FAULT;
      end
      ST_FAULT: begin
        if (!faulted) phase_next = ST_INIT;
      end
      default: begin
        if (hw_pre) phase_next = ST_PRE;
      end
    endcase
  end

  // exit and entry actions, then the per-phase led action
  always_comb begin
    relay_next       = relay;
    led_next         = led;
    flash_lit_next   = flash_lit;
    start_mid        = flash_start;

    if (phase_next != phase) begin
      if (phase == ST_WAIT) relay_next.pre = 1'b0;
      if (phase == ST_RUN) begin
        relay_next.run   = 1'b0;
        relay_next.ready = 1'b0;
      end
      unique case (phase_next)
        ST_PRE: begin
          relay_next.pre    = 1'b1;
          relay_next.enable = 1'b1;
        end
        ST_WAIT: start_mid = smp.now;
        ST_RUN: begin
          relay_next.run   = 1'b1;
          relay_next.ready = 1'b1;
        end
        ST_FAULT: relay_next.enable = 1'b0;
        default: begin
          relay_next.pre = 1'b0;
          relay_next.run = 1'b0;
        end
      endcase
    end

    // wrap-safe elapsed time for the wait flash
    elapsed          = smp.now - start_mid;
    flash_start_next = start_mid;

    unique case (phase_next)
      ST_PRE:  led_next = '{red: 1'b1, green: 1'b1, blue: 1'b0};
      ST_WAIT: begin
        if (elapsed > TIME_BITS'(cfg.flash_period)) begin
          led_next         = '{red: 1'b0, green: !flash_lit, blue: 1'b0};
          flash_lit_next   = !flash_lit;
          flash_start_next = smp.now;
        end
      end
      ST_RUN:  led_next = '{red: 1'b0, green: 1'b1, blue: 1'b0};
      ST_FAULT: begin
        if (f_cap) begin
          led_next            = '{red: 1'b0, green: 1'b0, blue: 1'b1};
          relay_next.shutdown = 1'b1;
        end else if (f_temp || f_cur) begin
          led_next            = '{red: 1'b1, green: 1'b0, blue: 1'b1};
          relay_next.shutdown = 1'b1;
        end else if (f_loop) begin
          led_next            = '{red: 1'b1, green: 1'b0, blue: 1'b0};
          relay_next.shutdown = 1'b0;
        end
      end
      default: led_next = '{red: 1'b1, green: 1'b1, blue: 1'b1};
    endcase
  end

  // result of this pass
  assign res = '{
    phase: phase_code(phase_next),
    relay: relay_next,
    led:   led_next,
    flags: {f_cap, f_loop, f_cur, f_temp}
  };

  // state registers advance only when the pass is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ST_INIT;
      flash_start <= '0;
      flash_lit   <= 1'b0;
      relay       <= '0;
      led         <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      flash_start <= flash_start_next;
      flash_lit   <= flash_lit_next;
      relay       <= relay_next;
      led         <= led_next;
    end
  end

endmodule
